### hdl/gls_pkg.sv
// Shared types and constants for the gradient line search block.
package gls_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ResBits  = 48;

  localparam logic [30:0] WORD_MAX = 31'h7FFF_FFFF;
  localparam logic [16:0] Q_ONE    = 17'h1_0000;
  localparam logic [47:0] Q_HALF   = 48'h0000_0000_8000;
  localparam logic [47:0] Q_LOW    = 48'h0000_0000_4000;
  localparam logic [47:0] Q_HIGH   = 48'h0000_0000_C000;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [1:0] ST_EVAL  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic [2:0] REG_TOL    = 3'd0;
  localparam logic [2:0] REG_TRIAL  = 3'd1;
  localparam logic [2:0] REG_MAXF   = 3'd2;
  localparam logic [2:0] REG_GROWTH = 3'd3;
  localparam logic [2:0] REG_BLIM   = 3'd4;
  localparam logic [2:0] REG_RLIM   = 3'd5;
  localparam logic [2:0] REG_FORG   = 3'd6;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] start_position;
    logic signed [31:0] derivative;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_position;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [30:0] grad_tolerance;
    logic [30:0] trial_step;
    logic [30:0] max_step_factor;
    logic [30:0] step_growth;
    logic [7:0]  bracket_limit;
    logic [7:0]  refine_limit;
    logic [7:0]  forgive_count;
  } cfg_t;

  // Request to the shared multiply/divide unit: u*v>>16, or u*v/w when div is set.
  typedef struct packed {
    logic        div;
    logic [47:0] u;
    logic [31:0] v;
    logic [31:0] w;
  } md_req_t;

  function automatic logic [31:0] magn(input logic signed [31:0] x);
    logic signed [31:0] n;
    n = -x;
    return x[31] ? n : x;
  endfunction

  function automatic logic [31:0] dmag(input logic signed [31:0] x,
                                       input logic signed [31:0] y);
    logic signed [32:0] df;
    logic signed [32:0] nd;
    df = {x[31], x} - {y[31], y};
    nd = -df;
    return df[32] ? nd[31:0] : df[31:0];
  endfunction

  // x plus or minus a magnitude, saturated to the signed word.
  function automatic logic signed [31:0] add_mag(input logic signed [31:0] x,
                                                 input logic neg,
                                                 input logic [48:0] m);
    logic signed [50:0] xs;
    logic signed [50:0] ms;
    logic signed [50:0] s;
    xs = {{19{x[31]}}, x};
    ms = $signed({2'b00, m});
    s  = neg ? (xs - ms) : (xs + ms);
    if (s > 51'sh0_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -51'sh0_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

endpackage

### hdl/gls_muldiv.sv
// Shared serial unit: shift-add multiply, then optional restoring division.
module gls_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  gls_pkg::md_req_t  req_i,
  output logic              done_o,
  output logic [47:0]       res_o
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_e;

  md_state_e   state_q;
  logic [79:0] acc_q;
  logic [79:0] mcand_q;
  logic [31:0] mplier_q;
  logic [5:0]  cnt_q;
  logic        div_q;
  logic [31:0] w_q;
  logic [31:0] rem_q;
  logic [47:0] quo_q;
  logic        done_q;
  logic [47:0] res_q;

  logic [79:0] acc_nx;
  logic [32:0] rem_sh;
  logic        rem_ge;

  assign acc_nx = acc_q + (mplier_q[0] ? mcand_q : 80'd0);
  assign rem_sh = {rem_q, quo_q[47]};
  assign rem_ge = rem_sh >= {1'b0, w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      div_q    <= 1'b0;
      w_q      <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      res_q    <= '0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            acc_q    <= '0;
            mcand_q  <= {32'd0, req_i.u};
            mplier_q <= req_i.v;
            div_q    <= req_i.div;
            w_q      <= req_i.w;
            cnt_q    <= '0;
            state_q  <= M_MUL;
          end
        end
        M_MUL: begin
          acc_q    <= acc_nx;
          mcand_q  <= {mcand_q[78:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[31:1]};
          if (cnt_q == 6'd31) begin
            cnt_q <= '0;
            if (!div_q) begin
              res_q   <= (acc_nx[79:64] != 16'd0) ? '1 : acc_nx[63:16];
              done_q  <= 1'b1;
              state_q <= M_IDLE;
            end else if (w_q == 32'd0 || acc_nx[79:48] >= w_q) begin
              res_q   <= '1;
              done_q  <= 1'b1;
              state_q <= M_IDLE;
            end else begin
              rem_q   <= acc_nx[79:48];
              quo_q   <= acc_nx[47:0];
              done_q  <= 1'b0;
              state_q <= M_DIV;
            end
          end else begin
            cnt_q  <= cnt_q + 6'd1;
            done_q <= 1'b0;
          end
        end
        M_DIV: begin
          rem_q <= rem_ge ? 32'(rem_sh - {1'b0, w_q}) : rem_sh[31:0];
          quo_q <= {quo_q[46:0], rem_ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) begin
            res_q   <= {quo_q[46:0], rem_ge};
            done_q  <= 1'b1;
            state_q <= M_IDLE;
          end else begin
            done_q <= 1'b0;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= M_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/gls_regs.sv
// APB register file holding the search settings.
module gls_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gls_pkg::cfg_t      cfg_o
);

  gls_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grad_tolerance  <= 31'd66;
      cfg_q.trial_step      <= 31'd6554;
      cfg_q.max_step_factor <= 31'd327680;
      cfg_q.step_growth     <= 31'd131072;
      cfg_q.bracket_limit   <= 8'd5;
      cfg_q.refine_limit    <= 8'd5;
      cfg_q.forgive_count   <= 8'd1;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        gls_pkg::REG_TOL:    cfg_q.grad_tolerance  <= pwdata[30:0];
        gls_pkg::REG_TRIAL:  cfg_q.trial_step      <= pwdata[30:0];
        gls_pkg::REG_MAXF:   cfg_q.max_step_factor <= pwdata[30:0];
        gls_pkg::REG_GROWTH: cfg_q.step_growth     <= pwdata[30:0];
        gls_pkg::REG_BLIM:   cfg_q.bracket_limit   <= pwdata[7:0];
        gls_pkg::REG_RLIM:   cfg_q.refine_limit    <= pwdata[7:0];
        gls_pkg::REG_FORG:   cfg_q.forgive_count   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      gls_pkg::REG_TOL:    prdata = {1'b0, cfg_q.grad_tolerance};
      gls_pkg::REG_TRIAL:  prdata = {1'b0, cfg_q.trial_step};
      gls_pkg::REG_MAXF:   prdata = {1'b0, cfg_q.max_step_factor};
      gls_pkg::REG_GROWTH: prdata = {1'b0, cfg_q.step_growth};
      gls_pkg::REG_BLIM:   prdata = {24'd0, cfg_q.bracket_limit};
      gls_pkg::REG_RLIM:   prdata = {24'd0, cfg_q.refine_limit};
      gls_pkg::REG_FORG:   prdata = {24'd0, cfg_q.forgive_count};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/gradient_line_search.sv
// Top level of the gradient-only line search sequencer (bracketing, then regula falsi).
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_stall_o  in_i  (cmd, start_position, derivative)
//   out       output     out_valid_o / out_stall_i out_o (next_position, status)
//   config    input      APB psel/penable/pwrite  7 registers at byte address 4*i
//
// An item is taken while the block is idle; it then occupies the block until its result is in
// the output register. The shared multiply/divide unit forms a product and, for a division,
// then a quotient. A bracketing step passes the step cap and then a grown step or a secant
// guess through the unit before its result is registered; a refinement step divides for the
// secant ratio, except when the derivatives at both ends are equal, and then multiplies for a
// secant point or falls back to the midpoint. A found or limit answer goes through S_RESULT,
// with S_FIN before it when the best end is picked. A report that arrives with no search
// running is taken and gives no result. Reset needs no clearing pass. A waiting result does not
// stop the next transfer in; the block only waits at its end if the old result is still held.
module gradient_line_search (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gls_pkg::in_t    in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gls_pkg::out_t   out_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_CAP, S_CAP_W, S_STEP_W, S_PROP, S_Z_W, S_Z_EVAL, S_PT_W, S_FIN, S_RESULT
  } state_e;

  typedef enum logic [1:0] {PH_IDLE, PH_BRACKET, PH_REFINE} phase_e;

  gls_pkg::cfg_t    cfg;
  gls_pkg::md_req_t md_req_q;
  logic             md_start_q;
  logic             md_done;
  logic [47:0]      md_res;

  state_e             state_q;
  phase_e             phase_q;
  logic signed [31:0] end_a_q, end_b_q, da_q, db_q, probe_q;
  logic signed [31:0] fin_x_q, fin_d_q;
  logic               desc_q;
  logic [30:0]        step_q, cap_q;
  logic [7:0]         iter_q, forg_q;
  logic [47:0]        zq_q;
  logic               zneg_q;
  logic signed [31:0] pend_pos_q;
  logic [1:0]         pend_st_q;
  gls_pkg::out_t      out_q;
  logic               out_valid_q;

  gls_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gls_muldiv u_md (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start_q),
    .req_i   (md_req_q),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  // Input side decisions.
  logic signed [31:0] d;
  logic [31:0]        d_mag;
  logic               tiny;
  logic               past;
  logic               swap_b;
  logic [7:0]         iter_inc;
  logic               in_xfer;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign d          = in_i.derivative;
  assign d_mag      = gls_pkg::magn(d);
  assign tiny       = d_mag < {1'b0, cfg.grad_tolerance};
  assign past       = (d_mag > {1'b0, cfg.grad_tolerance}) &&
                      ((!desc_q && d[31]) || (desc_q && !d[31] && d != 32'sd0));
  assign swap_b     = (d != 32'sd0) && (da_q != 32'sd0) && (d[31] != da_q[31]);
  assign iter_inc   = iter_q + 8'd1;

  // Bracket quantities from the stored ends.
  logic [31:0] ma, mb, ab_dist, den;
  logic        sec, dneg;
  assign ma      = gls_pkg::magn(da_q);
  assign mb      = gls_pkg::magn(db_q);
  assign sec     = mb < ma;
  assign ab_dist = gls_pkg::dmag(end_a_q, end_b_q);
  assign den     = gls_pkg::dmag(db_q, da_q);
  assign dneg    = db_q < da_q;

  // Step selection once the second unit pass is done.
  logic [48:0]        sec_t;
  logic [30:0]        dx;
  logic [30:0]        grown;
  logic signed [31:0] next_b;
  assign sec_t  = {1'b0, md_res} + {2'b00, md_res[47:1]};
  assign dx     = sec ? ((sec_t < {18'd0, cap_q}) ? sec_t[30:0] : cap_q) : step_q;
  assign grown  = (md_res < {17'd0, cap_q}) ? md_res[30:0] : cap_q;
  assign next_b = gls_pkg::add_mag(end_b_q, !desc_q, {18'd0, dx});

  // Refinement point candidates.
  logic               z_bad;
  logic signed [31:0] mid_pt;
  logic signed [31:0] sec_pt;
  assign z_bad  = zneg_q || (zq_q < gls_pkg::Q_LOW) || (zq_q > gls_pkg::Q_HIGH);
  assign mid_pt = gls_pkg::add_mag(end_a_q, end_b_q < end_a_q, {18'd0, ab_dist[31:1]});
  assign sec_pt = gls_pkg::add_mag(end_b_q, zneg_q != (end_a_q < end_b_q), {1'b0, md_res});

  // On the refinement limit, answer with the point of smallest derivative magnitude.
  logic signed [31:0] best_pos;
  always_comb begin
    logic [31:0] bm;
    best_pos = fin_x_q;
    bm       = gls_pkg::magn(fin_d_q);
    if (ma < bm) begin
      best_pos = end_a_q;
      bm       = ma;
    end
    if (mb < bm) begin
      best_pos = end_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      end_a_q     <= '0;
      end_b_q     <= '0;
      da_q        <= '0;
      db_q        <= '0;
      probe_q     <= '0;
      fin_x_q     <= '0;
      fin_d_q     <= '0;
      desc_q      <= 1'b0;
      step_q      <= '0;
      cap_q       <= '0;
      iter_q      <= '0;
      forg_q      <= '0;
      zq_q        <= '0;
      zneg_q      <= 1'b0;
      pend_pos_q  <= '0;
      pend_st_q   <= gls_pkg::ST_EVAL;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      md_req_q    <= '0;
      md_start_q  <= 1'b0;
    end else begin
      // The shared unit is launched from the states that hand it a new request.
      md_start_q <= (state_q == S_CAP) || (state_q == S_CAP_W && md_done) ||
                    (state_q == S_PROP && den != 32'd0) ||
                    (state_q == S_Z_EVAL && !(z_bad && forg_q == 8'd0));
      if (state_q != S_RESULT && out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_i.cmd == gls_pkg::CMD_START) begin
              end_a_q <= in_i.start_position;
              end_b_q <= in_i.start_position;
              probe_q <= in_i.start_position;
              da_q    <= '0;
              db_q    <= d;
              if (tiny) begin
                pend_pos_q <= in_i.start_position;
                pend_st_q  <= gls_pkg::ST_FOUND;
                phase_q    <= PH_IDLE;
                state_q    <= S_RESULT;
              end else begin
                desc_q <= d[31];
                step_q <= cfg.trial_step;
                iter_q <= '0;
                if (cfg.bracket_limit == 8'd0) begin
                  pend_pos_q <= in_i.start_position;
                  pend_st_q  <= gls_pkg::ST_LIMIT;
                  phase_q    <= PH_IDLE;
                  state_q    <= S_RESULT;
                end else begin
                  phase_q <= PH_BRACKET;
                  state_q <= S_CAP;
                end
              end
            end else if (phase_q == PH_BRACKET) begin
              db_q <= d;
              if (tiny) begin
                pend_pos_q <= end_b_q;
                pend_st_q  <= gls_pkg::ST_FOUND;
                phase_q    <= PH_IDLE;
                state_q    <= S_RESULT;
              end else if (past) begin
                iter_q <= '0;
                forg_q <= cfg.forgive_count;
                if (cfg.refine_limit == 8'd0) begin
                  fin_x_q <= end_b_q;
                  fin_d_q <= d;
                  state_q <= S_FIN;
                end else begin
                  phase_q <= PH_REFINE;
                  state_q <= S_PROP;
                end
              end else begin
                iter_q <= iter_inc;
                if (iter_inc >= cfg.bracket_limit) begin
                  pend_pos_q <= end_b_q;
                  pend_st_q  <= gls_pkg::ST_LIMIT;
                  phase_q    <= PH_IDLE;
                  state_q    <= S_RESULT;
                end else begin
                  state_q <= S_CAP;
                end
              end
            end else if (phase_q == PH_REFINE) begin
              if (tiny) begin
                pend_pos_q <= probe_q;
                pend_st_q  <= gls_pkg::ST_FOUND;
                phase_q    <= PH_IDLE;
                state_q    <= S_RESULT;
              end else begin
                if (swap_b) begin
                  end_b_q <= probe_q;
                  db_q    <= d;
                end else begin
                  end_a_q <= probe_q;
                  da_q    <= d;
                end
                iter_q <= iter_inc;
                if (iter_inc >= cfg.refine_limit) begin
                  fin_x_q <= probe_q;
                  fin_d_q <= d;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_PROP;
                end
              end
            end
          end
        end
        S_CAP: begin
          // Step cap is trial_step times the cap factor.
          md_req_q <= '{div: 1'b0, u: {17'd0, cfg.trial_step},
                        v: {1'b0, cfg.max_step_factor}, w: 32'd0};
          state_q  <= S_CAP_W;
        end
        S_CAP_W: begin
          if (md_done) begin
            cap_q <= (md_res > {17'd0, gls_pkg::WORD_MAX}) ? gls_pkg::WORD_MAX : md_res[30:0];
            if (sec) begin
              md_req_q <= '{div: 1'b1, u: {16'd0, mb}, v: ab_dist, w: 32'(ma - mb)};
            end else begin
              md_req_q <= '{div: 1'b0, u: {17'd0, step_q},
                            v: {1'b0, cfg.step_growth}, w: 32'd0};
            end
            state_q <= S_STEP_W;
          end
        end
        S_STEP_W: begin
          if (md_done) begin
            if (!sec) begin
              step_q <= grown;
            end
            end_a_q    <= end_b_q;
            da_q       <= db_q;
            end_b_q    <= next_b;
            probe_q    <= next_b;
            pend_pos_q <= next_b;
            pend_st_q  <= gls_pkg::ST_EVAL;
            state_q    <= S_RESULT;
          end
        end
        S_PROP: begin
          if (den == 32'd0) begin
            zq_q    <= gls_pkg::Q_HALF;
            zneg_q  <= 1'b0;
            state_q <= S_Z_EVAL;
          end else begin
            md_req_q <= '{div: 1'b1, u: {16'd0, mb}, v: {15'd0, gls_pkg::Q_ONE}, w: den};
            state_q  <= S_Z_W;
          end
        end
        S_Z_W: begin
          if (md_done) begin
            zq_q    <= md_res;
            zneg_q  <= (md_res != 48'd0) && (db_q[31] != dneg);
            state_q <= S_Z_EVAL;
          end
        end
        S_Z_EVAL: begin
          if (z_bad && forg_q == 8'd0) begin
            // Too many poor secant points: fall back to the midpoint.
            probe_q    <= mid_pt;
            pend_pos_q <= mid_pt;
            pend_st_q  <= gls_pkg::ST_EVAL;
            state_q    <= S_RESULT;
          end else begin
            if (z_bad) begin
              forg_q <= forg_q - 8'd1;
            end
            md_req_q <= '{div: 1'b0, u: zq_q, v: ab_dist, w: 32'd0};
            state_q  <= S_PT_W;
          end
        end
        S_PT_W: begin
          if (md_done) begin
            probe_q    <= sec_pt;
            pend_pos_q <= sec_pt;
            pend_st_q  <= gls_pkg::ST_EVAL;
            state_q    <= S_RESULT;
          end
        end
        S_FIN: begin
          pend_pos_q <= best_pos;
          pend_st_q  <= gls_pkg::ST_LIMIT;
          phase_q    <= PH_IDLE;
          state_q    <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.next_position <= pend_pos_q;
            out_q.status        <= pend_st_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the gradient line search sequencer.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // Scoreboard with a bit-accurate predictor of the line search state machine.
  class search_scoreboard;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BRACKET = 2'd1;
    localparam logic [1:0] PH_REFINE = 2'd2;
    localparam longint unsigned WMAX = 64'h7FFF_FFFF;
    localparam longint unsigned QONE = 64'h1_0000;

    longint unsigned tol, trial, maxf, growth;
    int unsigned blim, rlim, forg;
    logic [1:0] phase;
    longint ea, eb, da, db, probe;
    bit dsign;
    int unsigned iters, forg_left;
    longint unsigned step;

    gls_pkg::out_t expected_q[$];
    gls_pkg::out_t last_result;
    int unsigned fails;

    function new();
      tol = 66; trial = 6554; maxf = 327680; growth = 131072;
      blim = 5; rlim = 5; forg = 1;
      phase = PH_IDLE;
      ea = 0; eb = 0; da = 0; db = 0; probe = 0;
      dsign = 0; iters = 0; forg_left = 0; step = 0; fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        gls_pkg::REG_TOL:    tol = val[30:0];
        gls_pkg::REG_TRIAL:  trial = val[30:0];
        gls_pkg::REG_MAXF:   maxf = val[30:0];
        gls_pkg::REG_GROWTH: growth = val[30:0];
        gls_pkg::REG_BLIM:   blim = val[7:0];
        gls_pkg::REG_RLIM:   rlim = val[7:0];
        gls_pkg::REG_FORG:   forg = val[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned abs_of(longint x);
      return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    function longint unsigned gap_of(longint x, longint y);
      return x >= y ? longint'(x - y) : longint'(y - x);
    endfunction

    function longint unsigned min_of(longint unsigned x, longint unsigned y);
      return x < y ? x : y;
    endfunction

    function longint sat_word(bit neg, longint unsigned m);
      if (!neg) return m > WMAX ? longint'(WMAX) : longint'(m);
      if (m > WMAX + 1) m = WMAX + 1;
      return -longint'(m);
    endfunction

    // x moved by a signed magnitude, saturated to the 32-bit word.
    function longint offset_sat(longint x, bit neg, longint unsigned m);
      bit xn;
      longint unsigned xm, s;
      xn = x < 0;
      xm = abs_of(x);
      if (xn == neg) begin
        s = xm + m;
        if (s < xm) s = '1;
        return sat_word(xn, s);
      end
      if (xm >= m) return sat_word(xn, xm - m);
      return sat_word(neg, m - xm);
    endfunction

    // floor(u*v/w) with saturation; a zero divisor gives the maximum.
    function longint unsigned mul_div(longint unsigned u, longint unsigned v,
                                      longint unsigned w);
      logic [127:0] p, q;
      if (w == 0) return '1;
      p = 128'(u) * 128'(v);
      q = p / 128'(w);
      if (q[127:64] != 0) return '1;
      return q[63:0];
    endfunction

    function longint unsigned step_cap();
      return min_of(mul_div(trial, maxf, QONE), WMAX);
    endfunction

    function void next_bracket_point();
      longint unsigned ma, mb, cap, dx, t, h;
      ma = abs_of(da);
      mb = abs_of(db);
      cap = step_cap();
      if (mb < ma) begin
        t = mul_div(mb, gap_of(ea, eb), ma - mb);
        h = t >> 1;
        t = (t > ~h) ? '1 : t + h;
        dx = min_of(t, cap);
      end else begin
        dx = step;
        step = min_of(mul_div(step, growth, QONE), cap);
      end
      ea = eb;
      da = db;
      eb = offset_sat(eb, dsign == 0, dx);
      probe = eb;
    endfunction

    // Secant point inside the bracket, or the midpoint once forgiveness runs out.
    function void next_refine_point();
      longint unsigned den, zq;
      bit dneg, zneg;
      den = gap_of(db, da);
      dneg = db < da;
      if (den == 0) begin
        zneg = 0;
        zq = QONE >> 1;
      end else begin
        zq = mul_div(abs_of(db), QONE, den);
        zneg = (zq != 0) && ((db < 0) != dneg);
      end
      if (zneg || zq < (QONE >> 2) || zq > 3 * (QONE >> 2)) begin
        if (forg_left > 0) begin
          forg_left--;
        end else begin
          probe = offset_sat(ea, eb < ea, gap_of(ea, eb) >> 1);
          return;
        end
      end
      probe = offset_sat(eb, zneg != (ea < eb), mul_div(zq, gap_of(ea, eb), QONE));
    endfunction

    function void emit(longint pos, logic [1:0] st);
      gls_pkg::out_t r;
      r.next_position = pos[31:0];
      r.status = st;
      last_result = r;
      expected_q.push_back(r);
    endfunction

    function void emit_best(longint x, longint dx);
      longint best;
      longint unsigned bm;
      best = x;
      bm = abs_of(dx);
      if (abs_of(da) < bm) begin
        best = ea;
        bm = abs_of(da);
      end
      if (abs_of(db) < bm) best = eb;
      emit(best, gls_pkg::ST_LIMIT);
      phase = PH_IDLE;
    endfunction

    // Notes one accepted input transfer; returns 1 when it yields a result.
    function bit note_input(gls_pkg::in_t it);
      longint d, x0, x;
      bit tiny, past;
      d = longint'(it.derivative);
      tiny = abs_of(d) < tol;
      if (it.cmd == gls_pkg::CMD_START) begin
        x0 = longint'(it.start_position);
        ea = x0; eb = x0; probe = x0;
        da = 0; db = d;
        if (tiny) begin
          emit(x0, gls_pkg::ST_FOUND);
          phase = PH_IDLE;
          return 1;
        end
        dsign = d < 0;
        step = min_of(trial, WMAX);
        iters = 0;
        if (blim == 0) begin
          emit(x0, gls_pkg::ST_LIMIT);
          phase = PH_IDLE;
          return 1;
        end
        next_bracket_point();
        phase = PH_BRACKET;
        emit(probe, gls_pkg::ST_EVAL);
        return 1;
      end
      if (phase == PH_BRACKET) begin
        past = abs_of(d) > tol && ((dsign == 0 && d < 0) || (dsign == 1 && d > 0));
        db = d;
        if (tiny) begin
          emit(eb, gls_pkg::ST_FOUND);
          phase = PH_IDLE;
          return 1;
        end
        if (past) begin
          iters = 0;
          forg_left = forg;
          if (rlim == 0) begin
            emit_best(eb, d);
            return 1;
          end
          next_refine_point();
          phase = PH_REFINE;
          emit(probe, gls_pkg::ST_EVAL);
          return 1;
        end
        iters++;
        if (iters >= blim) begin
          emit(eb, gls_pkg::ST_LIMIT);
          phase = PH_IDLE;
          return 1;
        end
        next_bracket_point();
        emit(probe, gls_pkg::ST_EVAL);
        return 1;
      end
      if (phase == PH_REFINE) begin
        x = probe;
        if (tiny) begin
          emit(x, gls_pkg::ST_FOUND);
          phase = PH_IDLE;
          return 1;
        end
        if (d != 0 && da != 0 && ((d < 0) != (da < 0))) begin
          eb = x;
          db = d;
        end else begin
          ea = x;
          da = d;
        end
        iters++;
        if (iters >= rlim) begin
          emit_best(x, d);
          return 1;
        end
        next_refine_point();
        emit(probe, gls_pkg::ST_EVAL);
        return 1;
      end
      // A report with no search running is dropped.
      return 0;
    endfunction

    function void check_result(gls_pkg::out_t got);
      gls_pkg::out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: next_position %0d status %0d",
               got.next_position, got.status);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (got.next_position !== want.next_position) begin
        $error("next_position mismatch: expected %0d actual %0d",
               want.next_position, got.next_position);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d actual %0d", want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  gls_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  gls_pkg::out_t out_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  search_scoreboard sb = new();

  // Flags shared by the stimulus and the output stall process.
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  gradient_line_search dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // Timeout guard: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_o);
  end

  // The receiver stalls in random bursts. On request it holds off for a long
  // stretch so that the block fills up and stalls its input; near the end of
  // the run it never stalls at all.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Waits until all predicted results are out and the block has gone quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_all(logic [30:0] tol, logic [30:0] trial, logic [30:0] maxf,
                           logic [30:0] growth, logic [7:0] blim, logic [7:0] rlim,
                           logic [7:0] forg);
    drain();
    write_reg(gls_pkg::REG_TOL, {1'($urandom), tol});
    write_reg(gls_pkg::REG_TRIAL, {1'($urandom), trial});
    write_reg(gls_pkg::REG_MAXF, {1'($urandom), maxf});
    write_reg(gls_pkg::REG_GROWTH, {1'($urandom), growth});
    write_reg(gls_pkg::REG_BLIM, {24'($urandom), blim});
    write_reg(gls_pkg::REG_RLIM, {24'($urandom), rlim});
    write_reg(gls_pkg::REG_FORG, {24'($urandom), forg});
  endtask

  // Offers one item and returns once it has been transferred; returns 1 when
  // the item produces a result, which is then in sb.last_result.
  task automatic send(gls_pkg::in_t it, output bit has_result);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    has_result = sb.note_input(it);
  endtask

  function automatic gls_pkg::in_t make_item(logic cmd, logic [31:0] pos, logic [31:0] der);
    gls_pkg::in_t it;
    it.cmd = cmd;
    it.start_position = pos;
    it.derivative = der;
    return it;
  endfunction

  // Derivative of a parabola with its minimum at xmin, saturated to the word.
  function automatic logic [31:0] slope_at(longint x, longint xmin, longint k);
    longint d;
    d = ((x - xmin) * k) >>> 16;
    if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
    if (d < -64'sh8000_0000) d = -64'sh8000_0000;
    return d[31:0];
  endfunction

  // Runs well-formed searches, answering each requested point from a random
  // parabola, with occasional noise, aborted searches and stray reports.
  task automatic run_searches(int unsigned budget);
    int unsigned stop_at;
    longint xmin, k, x;
    bit has;
    gls_pkg::in_t it;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      xmin = longint'($signed(32'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000));
      k = longint'($urandom_range(1 << 10, 8 << 16));
      case ($urandom_range(0, 5))
        0: x = longint'($signed(32'($urandom)));
        1: x = xmin;
        default: x = xmin + longint'($signed(32'($urandom_range(0, 8 << 16)))) - (4 << 16);
      endcase
      if (x > 64'sh7FFF_FFFF || x < -64'sh8000_0000) x = xmin;
      it = make_item(gls_pkg::CMD_START, x[31:0], slope_at(x, xmin, k));
      if ($urandom_range(0, 15) == 0) it.derivative = '0;
      send(it, has);
      while (has && sb.last_result.status == gls_pkg::ST_EVAL && items_sent < stop_at) begin
        if ($urandom_range(0, 40) == 0) break;
        x = longint'(sb.last_result.next_position);
        it = make_item(gls_pkg::CMD_REPORT, 32'($urandom), slope_at(x, xmin, k));
        if ($urandom_range(0, 12) == 0) it.derivative = 32'($urandom);
        send(it, has);
      end
      // Sometimes a report arrives when no search is running.
      if ($urandom_range(0, 6) == 0 && sb.phase == search_scoreboard::PH_IDLE) begin
        send(make_item(gls_pkg::CMD_REPORT, 32'($urandom), 32'($urandom)), has);
      end
    end
  endtask

  initial begin
    bit has;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray report, field extremes, zero and tiny derivatives,
    // restarts while busy.
    send(make_item(gls_pkg::CMD_REPORT, 32'h7FFF_FFFF, 32'h8000_0000), has);
    send(make_item(gls_pkg::CMD_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h7FFF_FFFF), has);
    send(make_item(gls_pkg::CMD_START, 32'h8000_0000, 32'h8000_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h8000_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, 32'hFFFF_FFFF, 32'h0000_7FFF), has);
    send(make_item(gls_pkg::CMD_START, '0, '0), has);
    send(make_item(gls_pkg::CMD_START, 32'h0001_0000, 32'd65), has);
    send(make_item(gls_pkg::CMD_START, 32'h0001_0000, 32'hFFFF_FFBF), has);
    send(make_item(gls_pkg::CMD_START, 32'hFFFF_0000, 32'h0001_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'hFFFF_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h0000_8000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'hFFFF_C000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h0000_0042), has);
    send(make_item(gls_pkg::CMD_START, 32'h1234_5678, 32'hFFF0_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'hFFF8_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h0010_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h0010_0000), has);
    send(make_item(gls_pkg::CMD_REPORT, '0, 32'h0000_0000), has);

    run_searches(60);

    // Pressure: the receiver holds off while items keep coming.
    hold_req = 1'b1;
    send(make_item(gls_pkg::CMD_START, 32'($urandom), 32'($urandom)), has);
    repeat (25) begin
      send(make_item(1'($urandom), 32'($urandom), 32'($urandom)), has);
    end

    // Zero tolerance: a zero start derivative walks downhill.
    write_all('0, 31'd6554, 31'd327680, 31'd131072, 8'd5, 8'd5, 8'd1);
    send(make_item(gls_pkg::CMD_START, 32'h0000_1000, '0), has);
    run_searches(60);

    // Zero limits and zero steps.
    write_all('0, '0, '0, '0, '0, '0, '0);
    run_searches(25);
    write_all(31'd100, 31'd20000, 31'd400000, 31'd150000, 8'd30, 8'd0, 8'd0);
    run_searches(40);

    // Largest values everywhere; every derivative of magnitude below 2^31-1 counts as zero.
    write_all('1, '1, '1, '1, 8'hFF, 8'hFF, 8'hFF);
    run_searches(25);

    // Huge steps with a small tolerance, long limits.
    write_all(31'd1, '1, '1, '1, 8'hFF, 8'hFF, 8'hFF);
    run_searches(40);

    // Assorted random settings.
    repeat (5) begin
      write_all(31'($urandom_range(0, 3000)), 31'($urandom_range(500, 1 << 18)),
                31'($urandom_range(1 << 15, 64 << 16)), 31'($urandom_range(1 << 15, 4 << 16)),
                8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                8'($urandom_range(0, 4)));
      run_searches(60);
    end

    // Final stretch with no idling on either side.
    write_all(31'd66, 31'd6554, 31'd327680, 31'd131072, 8'd12, 8'd12, 8'd2);
    calm = 1'b1;
    run_searches(60);

    drain();
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/gls_pkg.sv
hdl/gls_muldiv.sv
hdl/gls_regs.sv
hdl/gradient_line_search.sv
sim/tb_top.sv
